// ===== hw/rtl/twa_pkg.sv =====
package twa_pkg;

    localparam int DEF_ROTOR_COUNT = 6;
    localparam int WRENCH_LEN      = 6;
    localparam int CORDIC_STEPS    = 20;

    localparam logic [31:0] KF_INV_RESET     = 32'd1000000;
    localparam logic [15:0] MAX_SPEED_RESET  = 16'd12800;
    localparam logic [14:0] TILT_LIMIT_RESET = 15'd12861;

    // Quarter turn in CORDIC angle units of 2^-20 rad.
    localparam logic signed [22:0] HALF_PI_Z = 23'sd1647099;

    localparam logic [1:0] CFG_KF_INV     = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED  = 2'd1;
    localparam logic [1:0] CFG_TILT_LIMIT = 2'd2;

    localparam logic MODE_COMPUTE = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    function automatic logic signed [22:0] atan_of(input logic [4:0] i);
        logic signed [22:0] t;
        case (i)
            5'd0:    t = 23'sd823550;
            5'd1:    t = 23'sd486170;
            5'd2:    t = 23'sd256879;
            5'd3:    t = 23'sd130396;
            5'd4:    t = 23'sd65451;
            5'd5:    t = 23'sd32757;
            5'd6:    t = 23'sd16383;
            5'd7:    t = 23'sd8192;
            5'd8:    t = 23'sd4096;
            5'd9:    t = 23'sd2048;
            5'd10:   t = 23'sd1024;
            5'd11:   t = 23'sd512;
            5'd12:   t = 23'sd256;
            5'd13:   t = 23'sd128;
            5'd14:   t = 23'sd64;
            5'd15:   t = 23'sd32;
            5'd16:   t = 23'sd16;
            5'd17:   t = 23'sd8;
            5'd18:   t = 23'sd4;
            5'd19:   t = 23'sd2;
            default: t = 23'sd0;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/twa_if.sv =====
interface twa_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [6:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] moment_x;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;

    modport source (output valid, mode, coef_index, coef_value, force_x, force_y, force_z,
                    moment_x, moment_y, moment_z, input ready);
    modport sink (input valid, mode, coef_index, coef_value, force_x, force_y, force_z,
                  moment_x, moment_y, moment_z, output ready);
endinterface

interface twa_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         rotor_index;
    logic [15:0]        rotor_speed;
    logic signed [15:0] tilt_angle;
    logic               last;

    modport source (output valid, rotor_index, rotor_speed, tilt_angle, last, input ready);
    modport sink (input valid, rotor_index, rotor_speed, tilt_angle, last, output ready);
endinterface

interface twa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/twa_isqrt.sv =====
module twa_isqrt
    import twa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic [63:0] r_val;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] rem_t;
    logic [34:0] trial;

    // One result bit per cycle: bring down two radicand bits and try the next root bit.
    assign rem_t = {r_rem[32:0], r_val[63:62]};
    assign trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[61:0], 2'b00};
            if (rem_t >= trial) begin
                r_rem  <= rem_t - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_t;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/tilt_rotor_wrench_allocation_unit.sv =====
// Channel | Port  | Direction | Request carries
// --------+-------+-----------+---------------------------------------------
// input   | i_in  | sink      | mode, coef_index, coef_value, wrench
// result  | o_out | source    | rotor_index, rotor_speed, tilt_angle, last
// config  | i_cfg | sink      | index, data (always ready)
//
// A load request writes one coefficient into the matrix memory. A compute request streams
// the 12*ROTOR_COUNT coefficients of the matrix memory through the shared multiplier
// (one per cycle), then runs two square roots in turn for each rotor.
// Reset clears control state and sets config defaults; coefficient memory is not cleared.
// A stalled result holds the rotor sequencer in its output state.
module tilt_rotor_wrench_allocation_unit
    import twa_pkg::*;
#(
    parameter int ROTOR_COUNT = DEF_ROTOR_COUNT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    twa_in_if.sink    i_in,
    twa_out_if.source o_out,
    twa_cfg_if.sink   i_cfg
);

    localparam int ROWS = 2 * ROTOR_COUNT;
    localparam int MAT  = ROWS * WRENCH_LEN;
    localparam int AW   = $clog2(MAT);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MAC   = 10'b0000000010,
        S_SQ_A  = 10'b0000000100,
        S_SQ_B  = 10'b0000001000,
        S_SUM   = 10'b0000010000,
        S_ROOT1 = 10'b0000100000,
        S_GAIN  = 10'b0001000000,
        S_GAIN2 = 10'b0010000000,
        S_ROOT2 = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;

    logic [31:0] r_kf_inv;
    logic [15:0] r_max_speed;
    logic [14:0] r_tilt_limit;

    logic signed [31:0] mem [MAT];
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_w [WRENCH_LEN];
    logic signed [31:0] r_v [ROWS];

    logic [AW-1:0] r_addr;
    logic [2:0]    r_col;
    logic          r_iss_on;
    logic          r_s1_vld, r_s1_end, r_s2_vld, r_s2_end;
    logic [2:0]    r_s1_col, r_s2_col;
    logic signed [42:0] r_acc;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        r_prod;
    logic [63:0]        r_sq;

    logic signed [34:0] r_x, r_y;
    logic signed [22:0] r_z;
    logic [4:0]         r_cit;
    logic               r_zero;

    logic [2:0] r_rot;
    logic       r_out_vld;
    logic [2:0] r_out_idx;
    logic [15:0] r_out_speed;
    logic signed [15:0] r_out_tilt;
    logic        r_out_last;

    logic        in_acc, wr_en, issue, out_load;
    logic        sq_start, sq_done;
    logic [63:0] sq_rad;
    logic [31:0] sq_root;
    logic [31:0] abs_a, abs_b;
    logic signed [39:0] sh_prod;
    logic signed [42:0] n_acc;
    logic signed [31:0] sat_acc;
    logic signed [16:0] t_round, t_lim;
    logic signed [15:0] tilt_val;
    logic [15:0]        speed_val;

    assign in_acc = i_in.valid && i_in.ready;
    assign wr_en  = in_acc && (i_in.mode == MODE_LOAD) && ({1'b0, i_in.coef_index} < 8'(MAT));
    assign issue  = (r_state == S_MAC) && r_iss_on;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kf_inv     <= KF_INV_RESET;
            r_max_speed  <= MAX_SPEED_RESET;
            r_tilt_limit <= TILT_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KF_INV:     r_kf_inv     <= i_cfg.data;
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg.data[15:0];
                CFG_TILT_LIMIT: r_tilt_limit <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_in.coef_index[AW-1:0]] <= i_in.coef_value;
        end
        if (issue) begin
            r_rd_data <= mem[r_addr];
        end
    end

    assign abs_a = r_v[0][31] ? 32'(-r_v[0]) : 32'(r_v[0]);
    assign abs_b = r_v[1][31] ? 32'(-r_v[1]) : 32'(r_v[1]);

    // One shared multiplier: matrix products, the two squares and the thrust gain.
    always_comb begin
        case (r_state)
            S_MAC: begin
                mul_a = 33'(r_rd_data);
                mul_b = 33'(r_w[r_s1_col]);
            end
            S_SQ_A: begin
                mul_a = {1'b0, abs_a};
                mul_b = {1'b0, abs_a};
            end
            S_SQ_B: begin
                mul_a = {1'b0, abs_b};
                mul_b = {1'b0, abs_b};
            end
            default: begin
                mul_a = {1'b0, r_kf_inv};
                mul_b = {1'b0, sq_root};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign sh_prod = r_prod[63:24];
    assign n_acc   = ((r_s2_col == 3'd0) ? 43'sd0 : r_acc) + 43'(sh_prod);
    always_comb begin
        if (!n_acc[42] && (n_acc[41:31] != '0)) begin
            sat_acc = 32'sh7FFFFFFF;
        end else if (n_acc[42] && (n_acc[41:31] != '1)) begin
            sat_acc = 32'sh80000000;
        end else begin
            sat_acc = n_acc[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
        if (r_state == S_SQ_B) begin
            r_sq <= r_prod;
        end
        if (in_acc && (i_in.mode == MODE_COMPUTE)) begin
            r_w[0] <= i_in.force_x;
            r_w[1] <= i_in.force_y;
            r_w[2] <= i_in.force_z;
            r_w[3] <= i_in.moment_x;
            r_w[4] <= i_in.moment_y;
            r_w[5] <= i_in.moment_z;
        end
        if ((r_state == S_MAC) && r_s2_vld) begin
            r_acc <= n_acc;
            if (r_s2_col == 3'(WRENCH_LEN - 1)) begin
                for (int i = 0; i < ROWS - 1; i++) begin
                    r_v[i] <= r_v[(i + 1) % ROWS];
                end
                r_v[ROWS-1] <= sat_acc;
            end
        end else if ((r_state == S_OUT) && out_load) begin
            for (int i = 0; i < ROWS; i++) begin
                r_v[i] <= r_v[(i + 2) % ROWS];
            end
        end
    end

    // Issue counters and the tags that follow each coefficient down the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_on <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_addr   <= '0;
            r_col    <= '0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (in_acc && (i_in.mode == MODE_COMPUTE)) begin
                r_iss_on <= 1'b1;
                r_addr   <= '0;
                r_col    <= '0;
            end else if (issue) begin
                r_addr <= r_addr + AW'(1);
                r_col  <= (r_col == 3'(WRENCH_LEN - 1)) ? 3'd0 : r_col + 3'd1;
                if (r_addr == AW'(MAT - 1)) begin
                    r_iss_on <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col <= r_col;
        r_s1_end <= (r_addr == AW'(MAT - 1));
        r_s2_col <= r_s1_col;
        r_s2_end <= r_s1_end;
    end

    // CORDIC in vectoring mode, one iteration per cycle while the first root runs.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_cit  <= '0;
            r_zero <= (r_v[0] == 32'sd0) && (r_v[1] == 32'sd0);
            if (r_v[0][31]) begin
                if (!r_v[1][31]) begin
                    r_x <= 35'(r_v[1]);
                    r_y <= -35'(r_v[0]);
                    r_z <= HALF_PI_Z;
                end else begin
                    r_x <= -35'(r_v[1]);
                    r_y <= 35'(r_v[0]);
                    r_z <= -HALF_PI_Z;
                end
            end else begin
                r_x <= 35'(r_v[0]);
                r_y <= 35'(r_v[1]);
                r_z <= '0;
            end
        end else if ((r_state == S_ROOT1) && (r_cit < 5'(CORDIC_STEPS))) begin
            r_cit <= r_cit + 5'd1;
            if (r_y > 35'sd0) begin
                r_x <= r_x + (r_y >>> r_cit);
                r_y <= r_y - (r_x >>> r_cit);
                r_z <= r_z + atan_of(r_cit);
            end else begin
                r_x <= r_x - (r_y >>> r_cit);
                r_y <= r_y + (r_x >>> r_cit);
                r_z <= r_z - atan_of(r_cit);
            end
        end
    end

    assign t_round = 17'((r_z + 23'sd32) >>> 6);
    assign t_lim   = 17'(signed'({1'b0, r_tilt_limit}));
    always_comb begin
        if (r_zero) begin
            tilt_val = '0;
        end else if (t_round > t_lim) begin
            tilt_val = t_lim[15:0];
        end else if (t_round < -t_lim) begin
            tilt_val = 16'(-t_lim);
        end else begin
            tilt_val = t_round[15:0];
        end
    end
    assign speed_val = (sq_root > {16'd0, r_max_speed}) ? r_max_speed : sq_root[15:0];

    assign sq_start = (r_state == S_SUM) || (r_state == S_GAIN2);
    assign sq_rad   = (r_state == S_SUM) ? (r_sq + r_prod) : {8'd0, r_prod[63:8]};

    twa_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    assign out_load = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rot     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // In the output state the valid flag is handled by the load below.
            if (r_out_vld && o_out.ready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in.mode == MODE_COMPUTE)) begin
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (r_s2_vld && r_s2_end) begin
                        r_state <= S_SQ_A;
                        r_rot   <= '0;
                    end
                end
                S_SQ_A:  r_state <= S_SQ_B;
                S_SQ_B:  r_state <= S_SUM;
                S_SUM:   r_state <= S_ROOT1;
                S_ROOT1: begin
                    if (sq_done) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN:  r_state <= S_GAIN2;
                S_GAIN2: r_state <= S_ROOT2;
                S_ROOT2: begin
                    if (sq_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_vld <= 1'b1;
                        if (r_rot == 3'(ROTOR_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rot   <= r_rot + 3'd1;
                            r_state <= S_SQ_A;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_load) begin
            r_out_idx   <= r_rot;
            r_out_speed <= speed_val;
            r_out_tilt  <= tilt_val;
            r_out_last  <= (r_rot == 3'(ROTOR_COUNT - 1));
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.rotor_index = r_out_idx;
    assign o_out.rotor_speed = r_out_speed;
    assign o_out.tilt_angle  = r_out_tilt;
    assign o_out.last        = r_out_last;

    a_last_marks_final_rotor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == (o_out.rotor_index == 3'(ROTOR_COUNT - 1))))
        else $error("last flag does not match rotor index");

    a_root_done_when_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> ((r_state == S_ROOT1) || (r_state == S_ROOT2)))
        else $error("square root finished outside a wait state");

    a_cordic_done_before_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAIN) |-> (r_cit == 5'(CORDIC_STEPS)))
        else $error("tilt iterations not complete");

    a_mac_pipe_only_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_state == S_MAC))
        else $error("matrix product outside the product phase");

endmodule
